// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gcd_lcm assertion failed");
`define GL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gcd_lcm assertion failed");
`else
`define GL_ASSERT(lbl, prop)
`define GL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/gl_pkg.sv =====
package gl_pkg;
  localparam int WIDTH_DEF = 32;
  localparam int OPND_W    = 32;
  localparam int RES_W     = 63;

  typedef enum logic {
    CMD_GCD = 1'b0,
    CMD_LCM = 1'b1
  } gl_cmd_t;

  // handshake controls shared by the pipeline sections
  typedef struct packed {
    logic en;
    logic vld;
  } gl_ctl_t;
endpackage

// ===== rtl/core/gl_if.sv =====
interface gl_in_if import gl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [OPND_W-1:0] a_value;
  logic [OPND_W-1:0] b_value;
  modport source (output valid, cmd, a_value, b_value, input ready);
  modport sink (input valid, cmd, a_value, b_value, output ready);
endinterface

interface gl_out_if import gl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

// ===== rtl/core/gl_gcd_pipe.sv =====
// binary gcd, one reduction step per stage
module gl_gcd_pipe import gl_pkg::*; #(
  parameter int W    = WIDTH_DEF,
  parameter int SB_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gl_ctl_t            ctl_in,
  input  logic [W-1:0]       x_in,
  input  logic [W-1:0]       y_in,
  input  logic [SB_W-1:0]    sb_in,
  output logic               vld_out,
  output logic [W-1:0]       g_out,
  output logic [SB_W-1:0]    sb_out
);
  localparam int N  = 2 * W;
  localparam int KW = $clog2(W);

  logic            vld_r [1:N];
  logic [W-1:0]    x_r   [1:N];
  logic [W-1:0]    y_r   [1:N];
  logic [KW-1:0]   k_r   [1:N];
  logic [SB_W-1:0] sb_r  [1:N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic            vi;
    logic [W-1:0]    xi, yi, x_nxt, y_nxt, dxy, dyx;
    logic [KW-1:0]   ki, k_nxt;
    logic [SB_W-1:0] si;

    if (s == 0) begin : g_first
      assign vi = ctl_in.vld;
      assign xi = x_in;
      assign yi = y_in;
      assign ki = '0;
      assign si = sb_in;
    end else begin : g_next
      assign vi = vld_r[s];
      assign xi = x_r[s];
      assign yi = y_r[s];
      assign ki = k_r[s];
      assign si = sb_r[s];
    end

    assign dxy = xi - yi;
    assign dyx = yi - xi;

    always_comb begin
      x_nxt = xi;
      y_nxt = yi;
      k_nxt = ki;
      if (xi == '0 || yi == '0) begin
        // finished, hold
      end else if (!xi[0] && !yi[0]) begin
        x_nxt = xi >> 1;
        y_nxt = yi >> 1;
        k_nxt = ki + KW'(1);
      end else if (!xi[0]) begin
        x_nxt = xi >> 1;
      end else if (!yi[0]) begin
        y_nxt = yi >> 1;
      end else if (xi >= yi) begin
        x_nxt = dxy >> 1;
      end else begin
        y_nxt = dyx >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (ctl_in.en) begin
        vld_r[s+1] <= vi;
      end
      if (ctl_in.en) begin
        x_r[s+1]  <= x_nxt;
        y_r[s+1]  <= y_nxt;
        k_r[s+1]  <= k_nxt;
        sb_r[s+1] <= si;
      end
    end
  end

  assign vld_out = vld_r[N];
  assign g_out   = W'((x_r[N] | y_r[N]) << k_r[N]);
  assign sb_out  = sb_r[N];
endmodule

// ===== rtl/core/gl_div_pipe.sv =====
// restoring divider, one quotient bit per stage
module gl_div_pipe import gl_pkg::*; #(
  parameter int W    = WIDTH_DEF,
  parameter int SB_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gl_ctl_t            ctl_in,
  input  logic [W-1:0]       num_in,
  input  logic [W-1:0]       den_in,
  input  logic [SB_W-1:0]    sb_in,
  output logic               vld_out,
  output logic [W-1:0]       quo_out,
  output logic [SB_W-1:0]    sb_out
);
  logic            vld_r [1:W];
  logic [W-1:0]    rem_r [1:W];
  logic [W-1:0]    num_r [1:W];
  logic [W-1:0]    den_r [1:W];
  logic [W-1:0]    quo_r [1:W];
  logic [SB_W-1:0] sb_r  [1:W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic            vi;
    logic [W-1:0]    ri, ni, di, qi, rem_nxt;
    logic [W:0]      t, diff;
    logic            qbit;
    logic [SB_W-1:0] si;

    if (s == 0) begin : g_first
      assign vi = ctl_in.vld;
      assign ri = '0;
      assign ni = num_in;
      assign di = den_in;
      assign qi = '0;
      assign si = sb_in;
    end else begin : g_next
      assign vi = vld_r[s];
      assign ri = rem_r[s];
      assign ni = num_r[s];
      assign di = den_r[s];
      assign qi = quo_r[s];
      assign si = sb_r[s];
    end

    assign t       = {ri, ni[W-1]};
    assign diff    = t - {1'b0, di};
    assign qbit    = !diff[W];
    assign rem_nxt = qbit ? diff[W-1:0] : t[W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (ctl_in.en) begin
        vld_r[s+1] <= vi;
      end
      if (ctl_in.en) begin
        rem_r[s+1] <= rem_nxt;
        num_r[s+1] <= ni << 1;
        den_r[s+1] <= di;
        quo_r[s+1] <= {qi[W-2:0], qbit};
        sb_r[s+1]  <= si;
      end
    end
  end

  assign vld_out = vld_r[W];
  assign quo_out = quo_r[W];
  assign sb_out  = sb_r[W];
endmodule

// ===== rtl/core/gcd_lcm_unit_core.sv =====
// gcd / lcm unit
// in_ch carries cmd (0 gcd, 1 lcm) and two signed operands; the low WIDTH
// bits of each operand are used, sign-extended from bit WIDTH-1. out_ch
// carries one unsigned 63-bit result per input word, in order.
// Every result is the gcd or lcm of the operand magnitudes; the most
// negative operand counts as 2^(WIDTH-1). lcm with a zero operand gives
// the magnitude of the other operand.
// The datapath is a fully pipelined chain: an input register, 2*WIDTH binary
// gcd step stages, a shift stage, WIDTH restoring divider stages and two
// multiplier stages. One word can be accepted every cycle while out_ch is
// not stalled.
// The whole pipeline advances together: when out_ch holds a word that is not
// taken, every stage holds and in_ch.ready drops in the same cycle, so no
// word is lost or repeated. Synchronous reset clears every stage valid bit;
// no word is in flight afterwards and in_ch.ready is high.
module gcd_lcm_unit_core import gl_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  gl_in_if.sink    in_ch,
  gl_out_if.source out_ch
);
`include "assert_macros.svh"

  localparam int H      = WIDTH / 2;
  localparam int GSB_W  = 1 + 2 * WIDTH;
  localparam int DSB_W  = 2 + 3 * WIDTH;
  localparam int PLO_W  = WIDTH + H;
  localparam int PHI_W  = 2 * WIDTH - H;
  localparam int PROD_W = 2 * WIDTH;

  gl_ctl_t ctl0, ctl_g, ctl_d;
  logic    en;
  logic    out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // operand magnitudes
  logic [WIDTH-1:0] a_low, b_low, ma, mb;
  assign a_low = in_ch.a_value[WIDTH-1:0];
  assign b_low = in_ch.b_value[WIDTH-1:0];
  assign ma    = a_low[WIDTH-1] ? (~a_low + WIDTH'(1)) : a_low;
  assign mb    = b_low[WIDTH-1] ? (~b_low + WIDTH'(1)) : b_low;

  logic             in_vld_r;
  logic             in_cmd_r;
  logic [WIDTH-1:0] ma_r, mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_ch.valid;
    end
    if (en) begin
      in_cmd_r <= in_ch.cmd;
      ma_r     <= ma;
      mb_r     <= mb;
    end
  end

  assign ctl0 = '{en: en, vld: in_vld_r};

  // gcd chain
  logic             gcd_vld;
  logic [WIDTH-1:0] gcd_g;
  logic [GSB_W-1:0] gcd_sb;

  gl_gcd_pipe #(.W(WIDTH), .SB_W(GSB_W)) u_gcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl0),
    .x_in    (ma_r),
    .y_in    (mb_r),
    .sb_in   ({in_cmd_r, ma_r, mb_r}),
    .vld_out (gcd_vld),
    .g_out   (gcd_g),
    .sb_out  (gcd_sb)
  );

  logic             g_vld_r;
  logic             g_cmd_r;
  logic [WIDTH-1:0] g_r, g_ma_r, g_mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= gcd_vld;
    end
    if (en) begin
      g_r     <= gcd_g;
      g_cmd_r <= gcd_sb[GSB_W-1];
      g_ma_r  <= gcd_sb[2*WIDTH-1:WIDTH];
      g_mb_r  <= gcd_sb[WIDTH-1:0];
    end
  end

  assign ctl_g = '{en: en, vld: g_vld_r};

  // |a| / gcd
  logic             has_zero;
  logic             div_vld;
  logic [WIDTH-1:0] quo;
  logic [DSB_W-1:0] div_sb;

  assign has_zero = (g_ma_r == '0) || (g_mb_r == '0);

  gl_div_pipe #(.W(WIDTH), .SB_W(DSB_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_g),
    .num_in  (g_ma_r),
    .den_in  (g_r),
    .sb_in   ({g_cmd_r, has_zero, g_mb_r, g_r, g_ma_r | g_mb_r}),
    .vld_out (div_vld),
    .quo_out (quo),
    .sb_out  (div_sb)
  );

  // multiply by |b| in two half-width partial products
  logic             m_vld_r;
  logic             m_cmd_r, m_zero_r;
  logic [WIDTH-1:0] m_g_r, m_or_r;
  logic [PLO_W-1:0] p_lo_r;
  logic [PHI_W-1:0] p_hi_r;
  logic [WIDTH-1:0] d_mb;

  assign d_mb  = div_sb[3*WIDTH-1:2*WIDTH];
  assign ctl_d = '{en: en, vld: div_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (ctl_d.en) begin
      m_vld_r <= ctl_d.vld;
    end
    if (ctl_d.en) begin
      m_cmd_r  <= div_sb[DSB_W-1];
      m_zero_r <= div_sb[DSB_W-2];
      m_g_r    <= div_sb[2*WIDTH-1:WIDTH];
      m_or_r   <= div_sb[WIDTH-1:0];
      p_lo_r   <= PLO_W'(quo) * PLO_W'(d_mb[H-1:0]);
      p_hi_r   <= PHI_W'(quo) * PHI_W'(d_mb[WIDTH-1:H]);
    end
  end

  logic [PROD_W-1:0] prod;
  logic [RES_W-1:0]  res_nxt;
  logic [RES_W-1:0]  result_r;
  logic              out_cmd_r;

  assign prod = PROD_W'(p_lo_r) + (PROD_W'(p_hi_r) << H);

  always_comb begin
    if (m_cmd_r == CMD_GCD) begin
      res_nxt = RES_W'(m_g_r);
    end else if (m_zero_r) begin
      res_nxt = RES_W'(m_or_r);
    end else begin
      res_nxt = RES_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_vld_r;
    end
    if (en) begin
      result_r  <= res_nxt;
      out_cmd_r <= m_cmd_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = result_r;

  // a pending word that is not taken freezes the intake
  `GL_ASSERT_ALWAYS(a_stall_blocks_in, out_ch.valid && !out_ch.ready |-> !in_ch.ready)
  // gcd is zero only when both magnitudes are zero
  `GL_ASSERT(a_gcd_zero, g_vld_r && g_r == '0 |-> g_ma_r == '0 && g_mb_r == '0)
  // gcd never exceeds the operand width
  `GL_ASSERT(a_gcd_width, out_ch.valid && out_cmd_r == CMD_GCD |-> result_r >> WIDTH == '0)
  // gcd is nonzero when either magnitude is nonzero
  `GL_ASSERT(a_gcd_nonzero, g_vld_r && (g_ma_r != '0 || g_mb_r != '0) |-> g_r != '0)
endmodule

// ===== bench/gcd_lcm_unit_core_tb.sv =====
module gcd_lcm_unit_core_tb;
  import gl_pkg::*;

  localparam int LATENCY = 3 * WIDTH_DEF + 4;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gl_in_if  in_ch ();
  gl_out_if out_ch ();

  gcd_lcm_unit_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [RES_W-1:0] expected_results[$];
  int  errors = 0;
  int  words_sent = 0;
  int  words_seen = 0;
  int  gcd_count = 0;
  int  lcm_count = 0;
  int  idle_cycles = 0;
  bit  hold_sink = 1'b0;
  int  hold_len = 0;

  function automatic logic [31:0] mag_of(logic [OPND_W-1:0] raw);
    logic [31:0] v;
    v = raw;
    // most negative value wraps to 2^31, which fits unsigned
    if (v[31]) v = ~v + 32'd1;
    return v;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic logic [RES_W-1:0] gcd_lcm_of(gl_cmd_t cmd, logic [OPND_W-1:0] a,
                                                   logic [OPND_W-1:0] b);
    logic [63:0] ma, mb, g, res;
    ma = mag_of(a);
    mb = mag_of(b);
    if (cmd == CMD_GCD) res = euclid_gcd(ma, mb);
    else if (ma != 64'd0 && mb != 64'd0) begin
      g = euclid_gcd(ma, mb);
      res = (ma / g) * mb;
    end else res = ma | mb;
    return res[RES_W-1:0];
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.cmd     = 1'b0;
    in_ch.a_value = '0;
    in_ch.b_value = '0;
    out_ch.ready  = 1'b0;
  end

  // result sink with random stalls and one long forced hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_sink) begin
      out_ch.ready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_ch.ready <= 1'b0;
    end else begin
      hold_len <= gap_len();
      out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_ch.result);
        errors++;
      end else begin
        logic [RES_W-1:0] exp_r;
        exp_r = expected_results.pop_front();
        if (out_ch.result !== exp_r) begin
          $display("%0t: result mismatch expected %h actual %h", $time, exp_r,
                   out_ch.result);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake inactivity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("gcd_lcm_unit_core_tb: FAIL");
      $finish;
    end
  end

  task automatic send_word(gl_cmd_t cmd, logic [OPND_W-1:0] a, logic [OPND_W-1:0] b,
                           bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.a_value <= a;
    in_ch.b_value <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(gcd_lcm_of(cmd, a, b));
    words_sent++;
    if (cmd == CMD_GCD) gcd_count++;
    else lcm_count++;
  endtask

  task automatic end_stream();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_corner_operands();
    logic [OPND_W-1:0] corners[6];
    corners = '{32'h0, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd12};
    foreach (corners[i]) begin
      send_word(CMD_GCD, corners[i], corners[(i + 1) % 6]);
      send_word(CMD_LCM, corners[i], corners[(i + 2) % 6]);
    end
    send_word(CMD_GCD, 32'h0, 32'h0);
    send_word(CMD_LCM, 32'h0, 32'h0);
    send_word(CMD_LCM, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_LCM, 32'h7fff_ffff, 32'h7fff_fffe);
    send_word(CMD_GCD, -32'sd36, 32'd48);
    send_word(CMD_LCM, 32'd21, -32'sd6);
    end_stream();
  endtask

  function automatic logic [OPND_W-1:0] rand_operand();
    logic [OPND_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = $urandom_range(0, 255);
      2: v = 32'h0 - $urandom_range(0, 255);
      3: v = $urandom_range(1, 4096) * $urandom_range(1, 4096);
      default: v = (32'd1 << $urandom_range(0, 31)) ^ ($urandom_range(0, 1) ? 32'hffff_ffff : 0);
    endcase
    return v;
  endfunction

  task automatic test_random_words(int n);
    logic [31:0] f;
    for (int i = 0; i < n; i++) begin
      // shared factor makes nontrivial gcd more frequent
      if ($urandom_range(0, 2) == 0) begin
        f = $urandom_range(1, 60000);
        send_word(gl_cmd_t'($urandom_range(0, 1)), f * $urandom_range(0, 30000),
                  f * $urandom_range(0, 30000) * ($urandom_range(0, 1) ? -1 : 1));
      end else begin
        send_word(gl_cmd_t'($urandom_range(0, 1)), rand_operand(), rand_operand());
      end
    end
    end_stream();
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (LATENCY + 150) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 160; i++) send_word(gl_cmd_t'(i & 1), $urandom(), $urandom(), 1'b1);
    join
    end_stream();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_operands();
    test_backpressure();
    test_random_words(1250);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d words (%0d gcd, %0d lcm), %0d results checked", words_sent,
             gcd_count, lcm_count, words_seen);
    $display("included operand corners, zero operands and a long output hold-off");
    if (errors == 0) $display("gcd_lcm_unit_core_tb: PASS");
    else $display("gcd_lcm_unit_core_tb: FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gl_pkg.sv
rtl/core/gl_if.sv
rtl/core/gl_gcd_pipe.sv
rtl/core/gl_div_pipe.sv
rtl/core/gcd_lcm_unit_core.sv
bench/gcd_lcm_unit_core_tb.sv
